// ----- sv/ccc_pkg.sv -----
`default_nettype none
package ccc_pkg;

    localparam int unsigned DEF_MAX_CHUNKS = 256;

    localparam logic [31:0] RST_EXPECTED_VERSION = 32'd1;
    localparam logic [39:0] RST_MAX_FILE_BYTES   = 40'd268435456;
    localparam logic [8:0]  RST_MAX_CHUNKS       = 9'd256;
    localparam logic [31:0] RST_KNOWN_FLAG_MASK  = 32'd1;

    localparam logic [1:0] REG_EXPECTED_VERSION = 2'd0;
    localparam logic [1:0] REG_MAX_FILE_BYTES   = 2'd1;
    localparam logic [1:0] REG_MAX_CHUNKS       = 2'd2;
    localparam logic [1:0] REG_KNOWN_FLAG_MASK  = 2'd3;

    localparam logic [63:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;

    typedef struct packed {
        logic step;
        logic srch_start;
        logic srch_cmp;
        logic finish;
    } ccc_cmd_t;

    typedef struct packed {
        logic need_search;
        logic srch_more;
        logic out_free;
    } ccc_stat_t;

    // multiply by the FNV prime 2^40 + 0x1B3, modulo 2^64
    function automatic logic [63:0] fnv_mul(input logic [63:0] x);
        fnv_mul = (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

endpackage
`default_nettype wire

// ----- sv/ccc_ram.sv -----
`default_nettype none
module ccc_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- sv/ccc_ctrl.sv -----
`default_nettype none
module ccc_ctrl
    import ccc_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire ccc_stat_t st,
    output ccc_cmd_t       cmd
);
    typedef enum logic [1:0] {ST_ACCEPT, ST_SRD, ST_SCMP, ST_FINISH} state_t;

    state_t state_reg;
    logic   xfer;

    assign s_ready = (state_reg == ST_ACCEPT) && st.out_free;
    assign xfer    = s_valid && s_ready;

    always_comb begin
        cmd            = '0;
        cmd.step       = xfer;
        cmd.srch_start = xfer && st.need_search;
        cmd.srch_cmp   = (state_reg == ST_SCMP);
        cmd.finish     = (state_reg == ST_FINISH) && st.out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_ACCEPT;
        end else begin
            case (state_reg)
                ST_ACCEPT: begin
                    if (xfer && st.need_search) state_reg <= ST_SRD;
                end
                ST_SRD: begin
                    state_reg <= st.srch_more ? ST_SCMP : ST_FINISH;
                end
                ST_SCMP: state_reg <= ST_SRD;
                ST_FINISH: begin
                    if (st.out_free) state_reg <= ST_ACCEPT;
                end
                default: state_reg <= ST_ACCEPT;
            endcase
        end
    end

    a_fin_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> st.out_free) else $error("finish without free output");
    a_srch_go: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.srch_start |=> state_reg == ST_SRD) else $error("search not entered");
    a_cmp_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCMP |-> $past(state_reg) == ST_SRD) else $error("compare out of order");
    a_no_step: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_ACCEPT |-> !cmd.step) else $error("byte taken during search");
endmodule
`default_nettype wire

// ----- sv/ccc_datapath.sv -----
`default_nettype none
module ccc_datapath
    import ccc_pkg::*;
#(
    parameter int unsigned MAX_CHUNKS = DEF_MAX_CHUNKS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [39:0] cfg_wr_data,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_last,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_payload_valid,
    output logic [7:0]       m_payload_byte,
    output logic             m_chunk_done,
    output logic [31:0]      m_chunk_id,
    output logic [31:0]      m_chunk_version,
    output logic [31:0]      m_chunk_flags,
    output logic [39:0]      m_chunk_length,
    output logic             m_finished,
    output logic [3:0]       m_status,
    input  wire ccc_cmd_t    cmd,
    output ccc_stat_t        st
);
    localparam int unsigned AW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int unsigned CW = $clog2(MAX_CHUNKS + 1);

    typedef enum logic [2:0] {PH_FILE, PH_CHDR, PH_PAYLOAD, PH_TRAIL, PH_DRAIN} phase_t;

    localparam logic [2:0] HF_NONE    = 3'd0;
    localparam logic [2:0] HF_MAGIC   = 3'd1;
    localparam logic [2:0] HF_VERSION = 3'd2;
    localparam logic [2:0] HF_INCONS  = 3'd3;
    localparam logic [2:0] HF_COUNT   = 3'd4;

    localparam logic [3:0] S_BUSY      = 4'd0;
    localparam logic [3:0] S_OK        = 4'd1;
    localparam logic [3:0] S_HDR_SHORT = 4'd2;
    localparam logic [3:0] S_TOO_BIG   = 4'd3;
    localparam logic [3:0] S_MAGIC     = 4'd4;
    localparam logic [3:0] S_VERSION   = 4'd5;
    localparam logic [3:0] S_INCONS    = 4'd6;
    localparam logic [3:0] S_COUNT     = 4'd7;
    localparam logic [3:0] S_CHDR_SHRT = 4'd8;
    localparam logic [3:0] S_CHDR_BAD  = 4'd9;
    localparam logic [3:0] S_DUP_ID    = 4'd10;
    localparam logic [3:0] S_PAY_SHORT = 4'd11;
    localparam logic [3:0] S_HASH_BAD  = 4'd12;
    localparam logic [3:0] S_TRAILING  = 4'd13;

    localparam logic [40:0] SAT41 = '1;

    logic [31:0] exp_ver_reg;
    logic [39:0] max_bytes_reg;
    logic [8:0]  max_chunks_reg;
    logic [31:0] flag_mask_reg;

    phase_t      phase_reg, phase_next;
    logic [4:0]  pos_reg, pos_next;
    logic [40:0] seen_reg, seen_next;
    logic [63:0] asm_reg, asm_next;
    logic [63:0] total_reg, total_next;
    logic [31:0] count_reg, count_next;
    logic [CW-1:0] done_cnt_reg, done_cnt_next;
    logic [31:0] id_reg, id_next;
    logic [31:0] ver_reg, ver_next;
    logic [31:0] flags_reg, flags_next;
    logic [39:0] left_reg, left_next;
    logic [63:0] shash_reg, shash_next;
    logic [63:0] rhash_reg, rhash_next;
    logic [2:0]  hf_reg, hf_next;
    logic [3:0]  cf_reg, cf_next;
    logic        resv_reg, resv_next;
    logic        last_reg;
    logic [CW-1:0] idx_reg;
    logic        dup_reg;
    logic        m_valid_reg;

    logic        emit, out_pv, out_done, out_last, ram_we;
    logic [7:0]  out_pb;
    logic [3:0]  out_status;
    logic [39:0] out_len;
    logic [31:0] out_id, out_ver, out_flags;
    logic [31:0] ram_rdata;
    logic [31:0] chunk_limit;

    function automatic logic [7:0] magic_byte(input logic [2:0] i);
        case (i)
            3'd0: magic_byte = 8'h50;
            3'd1: magic_byte = 8'h32;
            3'd2: magic_byte = 8'h58;
            3'd3: magic_byte = 8'h53;
            3'd4: magic_byte = 8'h54;
            3'd5: magic_byte = 8'h41;
            3'd6: magic_byte = 8'h54;
            default: magic_byte = 8'h45;
        endcase
    endfunction

    assign chunk_limit = (32'(max_chunks_reg) > 32'(MAX_CHUNKS)) ? 32'(MAX_CHUNKS)
                                                                 : 32'(max_chunks_reg);

    assign st.need_search = (phase_reg == PH_CHDR) && (pos_reg == 5'd31);
    assign st.srch_more   = (idx_reg < done_cnt_reg);
    assign st.out_free    = !m_valid_reg || m_ready;

    ccc_ram #(.WIDTH(32), .DEPTH(MAX_CHUNKS)) u_ids (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (done_cnt_reg[AW-1:0]),
        .wdata (id_reg),
        .raddr (idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_comb begin
        logic [7:0]  b;
        logic [63:0] word;
        logic        close_req;
        logic        lst;
        logic [39:0] left_dec;

        b          = s_data_byte;
        word       = '0;
        close_req  = 1'b0;
        lst        = s_last;
        left_dec   = left_reg - 40'd1;
        emit       = 1'b0;
        out_pv     = 1'b0;
        out_pb     = '0;
        out_done   = 1'b0;
        ram_we     = 1'b0;

        phase_next    = phase_reg;
        pos_next      = pos_reg;
        seen_next     = seen_reg;
        asm_next      = asm_reg;
        total_next    = total_reg;
        count_next    = count_reg;
        done_cnt_next = done_cnt_reg;
        id_next       = id_reg;
        ver_next      = ver_reg;
        flags_next    = flags_reg;
        left_next     = left_reg;
        shash_next    = shash_reg;
        rhash_next    = rhash_reg;
        hf_next       = hf_reg;
        cf_next       = cf_reg;
        resv_next     = resv_reg;

        if (cmd.step) begin
            emit = !st.need_search;
            if (seen_reg != SAT41) seen_next = seen_reg + 41'd1;
            case (phase_reg)
                PH_FILE: begin
                    if (pos_reg < 5'd8) begin
                        if (b != magic_byte(pos_reg[2:0]) && hf_next == HF_NONE)
                            hf_next = HF_MAGIC;
                    end else if (pos_reg < 5'd24) begin
                        word = ((pos_reg[1:0] == 2'd0) ? 64'd0 : asm_reg)
                             | (64'(b) << {pos_reg[1:0], 3'b000});
                        asm_next = word;
                        if (pos_reg[1:0] == 2'd3) begin
                            if (pos_reg == 5'd11) begin
                                if (word[31:0] != exp_ver_reg && hf_next == HF_NONE)
                                    hf_next = HF_VERSION;
                            end else if (pos_reg == 5'd15) begin
                                if (word[31:0] != 32'd32 && hf_next == HF_NONE)
                                    hf_next = HF_INCONS;
                            end else if (pos_reg == 5'd19) begin
                                count_next = word[31:0];
                            end else begin
                                if (word[31:0] != 32'd0 && hf_next == HF_NONE)
                                    hf_next = HF_INCONS;
                            end
                        end
                    end else begin
                        total_next = total_reg | (64'(b) << {pos_reg[2:0], 3'b000});
                    end
                    if (pos_reg == 5'd31) begin
                        asm_next = '0;
                        if (count_reg > chunk_limit && hf_next == HF_NONE)
                            hf_next = HF_COUNT;
                        if (hf_next != HF_NONE) phase_next = PH_DRAIN;
                        else if (count_reg == 32'd0) phase_next = PH_TRAIL;
                        else phase_next = PH_CHDR;
                    end
                    pos_next = pos_reg + 5'd1;
                end
                PH_CHDR: begin
                    if (pos_reg == 5'd0) begin
                        id_next    = '0;
                        ver_next   = '0;
                        flags_next = '0;
                        asm_next   = '0;
                        shash_next = '0;
                        resv_next  = 1'b0;
                    end
                    if (pos_reg < 5'd4)
                        id_next = id_next | (32'(b) << {pos_reg[1:0], 3'b000});
                    else if (pos_reg < 5'd8)
                        ver_next = ver_reg | (32'(b) << {pos_reg[1:0], 3'b000});
                    else if (pos_reg < 5'd12)
                        flags_next = flags_reg | (32'(b) << {pos_reg[1:0], 3'b000});
                    else if (pos_reg < 5'd16) begin
                        if (b != 8'd0) resv_next = 1'b1;
                    end else if (pos_reg < 5'd24)
                        asm_next = asm_reg | (64'(b) << {pos_reg[2:0], 3'b000});
                    else
                        shash_next = shash_reg | (64'(b) << {pos_reg[2:0], 3'b000});
                    pos_next = pos_reg + 5'd1;
                end
                PH_PAYLOAD: begin
                    out_pv     = 1'b1;
                    out_pb     = b;
                    rhash_next = fnv_mul(rhash_reg ^ 64'(b));
                    left_next  = left_dec;
                    if (left_dec == 40'd0) close_req = 1'b1;
                end
                PH_TRAIL: begin
                    if (cf_next == 4'd0) cf_next = S_TRAILING;
                    phase_next = PH_DRAIN;
                end
                default: ;
            endcase
        end

        if (cmd.finish) begin
            emit = 1'b1;
            lst  = last_reg;
            if (resv_reg || (flags_reg & ~flag_mask_reg) != 32'd0) begin
                if (cf_next == 4'd0) cf_next = S_CHDR_BAD;
                phase_next = PH_DRAIN;
            end else if (dup_reg) begin
                if (cf_next == 4'd0) cf_next = S_DUP_ID;
                phase_next = PH_DRAIN;
            end else if (asm_reg > 64'(max_bytes_reg)) begin
                if (cf_next == 4'd0) cf_next = S_PAY_SHORT;
                phase_next = PH_DRAIN;
            end else begin
                ram_we     = 1'b1;
                left_next  = asm_reg[39:0];
                rhash_next = FNV_BASIS;
                if (asm_reg == 64'd0) close_req = 1'b1;
                else phase_next = PH_PAYLOAD;
            end
        end

        if (close_req) begin
            if (rhash_next != shash_next) begin
                if (cf_next == 4'd0) cf_next = S_HASH_BAD;
                phase_next = PH_DRAIN;
            end else begin
                done_cnt_next = done_cnt_reg + CW'(1);
                out_done      = 1'b1;
                phase_next    = (32'(done_cnt_next) >= count_next) ? PH_TRAIL : PH_CHDR;
            end
        end

        out_id    = id_next;
        out_ver   = ver_next;
        out_flags = flags_next;
        out_len   = (phase_next == PH_FILE) ? 40'd0 : asm_next[39:0];
        out_last  = lst;

        if (!lst) out_status = S_BUSY;
        else if (seen_next < 41'd32) out_status = S_HDR_SHORT;
        else if (seen_next > 41'(max_bytes_reg)) out_status = S_TOO_BIG;
        else if (hf_next == HF_MAGIC) out_status = S_MAGIC;
        else if (hf_next == HF_VERSION) out_status = S_VERSION;
        else if (hf_next == HF_INCONS || total_next != 64'(seen_next)) out_status = S_INCONS;
        else if (hf_next == HF_COUNT) out_status = S_COUNT;
        else if (cf_next != 4'd0) out_status = cf_next;
        else if (phase_next == PH_CHDR) out_status = S_CHDR_SHRT;
        else if (phase_next == PH_PAYLOAD) out_status = S_PAY_SHORT;
        else out_status = S_OK;

        if (emit && lst) begin
            phase_next    = PH_FILE;
            pos_next      = '0;
            seen_next     = '0;
            asm_next      = '0;
            total_next    = '0;
            count_next    = '0;
            done_cnt_next = '0;
            id_next       = '0;
            ver_next      = '0;
            flags_next    = '0;
            left_next     = '0;
            shash_next    = '0;
            rhash_next    = FNV_BASIS;
            hf_next       = HF_NONE;
            cf_next       = 4'd0;
            resv_next     = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_ver_reg    <= RST_EXPECTED_VERSION;
            max_bytes_reg  <= RST_MAX_FILE_BYTES;
            max_chunks_reg <= RST_MAX_CHUNKS;
            flag_mask_reg  <= RST_KNOWN_FLAG_MASK;
            phase_reg      <= PH_FILE;
            pos_reg        <= '0;
            seen_reg       <= '0;
            asm_reg        <= '0;
            total_reg      <= '0;
            count_reg      <= '0;
            done_cnt_reg   <= '0;
            id_reg         <= '0;
            ver_reg        <= '0;
            flags_reg      <= '0;
            left_reg       <= '0;
            shash_reg      <= '0;
            rhash_reg      <= FNV_BASIS;
            hf_reg         <= HF_NONE;
            cf_reg         <= 4'd0;
            resv_reg       <= 1'b0;
            idx_reg        <= '0;
            dup_reg        <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_EXPECTED_VERSION: exp_ver_reg    <= cfg_wr_data[31:0];
                    REG_MAX_FILE_BYTES:   max_bytes_reg  <= cfg_wr_data;
                    REG_MAX_CHUNKS:       max_chunks_reg <= cfg_wr_data[8:0];
                    REG_KNOWN_FLAG_MASK:  flag_mask_reg  <= cfg_wr_data[31:0];
                    default: ;
                endcase
            end
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            seen_reg     <= seen_next;
            asm_reg      <= asm_next;
            total_reg    <= total_next;
            count_reg    <= count_next;
            done_cnt_reg <= done_cnt_next;
            id_reg       <= id_next;
            ver_reg      <= ver_next;
            flags_reg    <= flags_next;
            left_reg     <= left_next;
            shash_reg    <= shash_next;
            rhash_reg    <= rhash_next;
            hf_reg       <= hf_next;
            cf_reg       <= cf_next;
            resv_reg     <= resv_next;
            if (cmd.srch_start) begin
                idx_reg <= '0;
                dup_reg <= 1'b0;
            end else if (cmd.srch_cmp) begin
                idx_reg <= idx_reg + CW'(1);
                if (ram_rdata == id_reg) dup_reg <= 1'b1;
            end
            if (emit) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.step) last_reg <= s_last;
        if (emit) begin
            m_payload_valid <= out_pv;
            m_payload_byte  <= out_pb;
            m_chunk_done    <= out_done;
            m_chunk_id      <= out_id;
            m_chunk_version <= out_ver;
            m_chunk_flags   <= out_flags;
            m_chunk_length  <= out_len;
            m_finished      <= out_last;
            m_status        <= out_status;
        end
    end

    assign m_valid = m_valid_reg;

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> st.out_free) else $error("result overwritten");
    a_ram_wr: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> 32'(done_cnt_reg) < 32'(MAX_CHUNKS)) else $error("id store overflow");
    a_cnt_lim: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(done_cnt_reg) <= 32'(MAX_CHUNKS)) else $error("chunk count beyond store");
endmodule
`default_nettype wire

// ----- sv/chunk_container_checker_top.sv -----
`default_nettype none
// Streaming checker for a chunked save-state container. Bytes enter on the
// s_ channel, one per transfer, with s_last on the final byte; each byte
// yields one result on the m_ channel. Payload bytes are forwarded before
// their hash is verified, so discard them unless the final status is ok.
// Bytes are taken while the output register is free; the last byte of each
// chunk header also waits for the duplicate-id search, which walks the ids
// of this file's finished chunks through the RAM's registered read port.
// Configuration must be written only while idle; the block does not enforce it.
module chunk_container_checker_top
    import ccc_pkg::*;
#(
    parameter int unsigned MAX_CHUNKS = DEF_MAX_CHUNKS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [39:0] cfg_wr_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_last,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_payload_valid,
    output logic [7:0]       m_payload_byte,
    output logic             m_chunk_done,
    output logic [31:0]      m_chunk_id,
    output logic [31:0]      m_chunk_version,
    output logic [31:0]      m_chunk_flags,
    output logic [39:0]      m_chunk_length,
    output logic             m_finished,
    output logic [3:0]       m_status
);
    ccc_cmd_t  cmd;
    ccc_stat_t st;

    ccc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    ccc_datapath #(.MAX_CHUNKS(MAX_CHUNKS)) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .s_data_byte     (s_data_byte),
        .s_last          (s_last),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_payload_valid (m_payload_valid),
        .m_payload_byte  (m_payload_byte),
        .m_chunk_done    (m_chunk_done),
        .m_chunk_id      (m_chunk_id),
        .m_chunk_version (m_chunk_version),
        .m_chunk_flags   (m_chunk_flags),
        .m_chunk_length  (m_chunk_length),
        .m_finished      (m_finished),
        .m_status        (m_status),
        .cmd             (cmd),
        .st              (st)
    );
endmodule
`default_nettype wire

// ----- tb/chunk_container_checker_mon.sv -----
module chunk_container_checker_mon
    import ccc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [39:0] cfg_wr_data,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_last,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic        m_payload_valid,
    input  wire logic [7:0]  m_payload_byte,
    input  wire logic        m_chunk_done,
    input  wire logic [31:0] m_chunk_id,
    input  wire logic [31:0] m_chunk_version,
    input  wire logic [31:0] m_chunk_flags,
    input  wire logic [39:0] m_chunk_length,
    input  wire logic        m_finished,
    input  wire logic [3:0]  m_status,
    output int               fail_count,
    output int               pending
);
    typedef enum logic [2:0] {
        PH_FILE, PH_CHDR, PH_PAYLOAD, PH_TRAIL, PH_DRAIN
    } phase_e;
    typedef enum logic [2:0] {
        HF_NONE, HF_MAGIC, HF_VERSION, HF_INCONS, HF_COUNT
    } hfault_e;
    localparam logic [3:0] ST_BUSY = 4'd0, ST_OK = 4'd1, ST_HDR_SHORT = 4'd2,
        ST_TOO_BIG = 4'd3, ST_MAGIC = 4'd4, ST_VERSION = 4'd5, ST_INCONS = 4'd6,
        ST_COUNT = 4'd7, ST_CHDR_SHORT = 4'd8, ST_CHDR_BAD = 4'd9,
        ST_DUP = 4'd10, ST_PAY_SHORT = 4'd11, ST_HASH = 4'd12, ST_TRAIL = 4'd13;
    localparam logic [63:0] PRIME = 64'd1099511628211;
    localparam logic [40:0] SAT = {41{1'b1}};

    typedef struct packed {
        logic        pv;
        logic [7:0]  pb;
        logic        done;
        logic [31:0] id;
        logic [31:0] ver;
        logic [31:0] flags;
        logic [39:0] len;
        logic        fin;
        logic [3:0]  status;
    } byte_result_t;

    byte_result_t result_q[$];

    logic [31:0] exp_version;
    logic [39:0] max_bytes;
    logic [8:0]  max_chunk_cnt;
    logic [31:0] flag_mask;

    phase_e      phase;
    logic [4:0]  fpos;
    logic [40:0] nbytes;
    logic [63:0] asm_word, decl_total, pay_left, hash_want, hash_run;
    logic [31:0] decl_count, cur_id, cur_ver, cur_flags;
    logic [8:0]  nfinished;
    hfault_e     hfault;
    logic [3:0]  cfault;
    logic        rsv_bad;
    logic [31:0] ids[256];

    function automatic logic [7:0] magic_at(input int p);
        logic [63:0] m;
        m = "ETATSX2P";
        return m[8*p +: 8];
    endfunction

    function automatic logic [8:0] limit();
        return (max_chunk_cnt > 9'd256) ? 9'd256 : max_chunk_cnt;
    endfunction

    task automatic restart();
        phase = PH_FILE; fpos = 0; nbytes = 0; asm_word = 0; decl_total = 0;
        decl_count = 0; nfinished = 0; cur_id = 0; cur_ver = 0; cur_flags = 0;
        pay_left = 0; hash_want = 0; hash_run = 64'd14695981039346656037;
        hfault = HF_NONE; cfault = 0; rsv_bad = 0;
    endtask

    function automatic void chunk_fault(input logic [3:0] c);
        if (cfault == 0) cfault = c;
        phase = PH_DRAIN;
    endfunction

    function automatic logic close_payload();
        if (hash_run != hash_want) begin
            chunk_fault(ST_HASH);
            return 0;
        end
        nfinished++;
        phase = ({23'd0, nfinished} >= decl_count) ? PH_TRAIL : PH_CHDR;
        return 1;
    endfunction

    function automatic logic [3:0] verdict();
        if (nbytes < 32) return ST_HDR_SHORT;
        if (nbytes > {1'b0, max_bytes}) return ST_TOO_BIG;
        if (hfault == HF_MAGIC) return ST_MAGIC;
        if (hfault == HF_VERSION) return ST_VERSION;
        if (hfault == HF_INCONS || decl_total != {23'd0, nbytes}) return ST_INCONS;
        if (hfault == HF_COUNT) return ST_COUNT;
        if (cfault != 0) return cfault;
        if (phase == PH_CHDR) return ST_CHDR_SHORT;
        if (phase == PH_PAYLOAD) return ST_PAY_SHORT;
        return ST_OK;
    endfunction

    task automatic predict_byte(input logic [7:0] b, input logic lst);
        byte_result_t r;
        int p;
        logic [31:0] w;
        logic dup;
        r = '0;
        p = fpos;
        if (nbytes != SAT) nbytes++;
        case (phase)
            PH_FILE: begin
                if (p < 8) begin
                    if (b != magic_at(p) && hfault == HF_NONE) hfault = HF_MAGIC;
                end else if (p < 24) begin
                    if ((p & 3) == 0) asm_word = 0;
                    asm_word |= 64'(b) << (8 * (p & 3));
                    if ((p & 3) == 3) begin
                        w = asm_word[31:0];
                        if (p == 11 && w != exp_version) begin
                            if (hfault == HF_NONE) hfault = HF_VERSION;
                        end else if (p == 15 && w != 32) begin
                            if (hfault == HF_NONE) hfault = HF_INCONS;
                        end else if (p == 19) begin
                            decl_count = w;
                        end else if (p == 23 && w != 0) begin
                            if (hfault == HF_NONE) hfault = HF_INCONS;
                        end
                    end
                end else begin
                    decl_total |= 64'(b) << (8 * (p - 24));
                end
                if (p == 31) begin
                    asm_word = 0;
                    if (decl_count > {23'd0, limit()} && hfault == HF_NONE)
                        hfault = HF_COUNT;
                    if (hfault != HF_NONE) phase = PH_DRAIN;
                    else phase = (decl_count == 0) ? PH_TRAIL : PH_CHDR;
                end
                fpos = fpos + 1;
            end
            PH_CHDR: begin
                if (p == 0) begin
                    cur_id = 0; cur_ver = 0; cur_flags = 0; asm_word = 0;
                    hash_want = 0; rsv_bad = 0;
                end
                if (p < 4) cur_id[8*(p&3) +: 8] = b;
                else if (p < 8) cur_ver[8*(p&3) +: 8] = b;
                else if (p < 12) cur_flags[8*(p&3) +: 8] = b;
                else if (p < 16) begin
                    if (b != 0) rsv_bad = 1;
                end else if (p < 24) asm_word[8*(p-16) +: 8] = b;
                else hash_want[8*(p-24) +: 8] = b;
                if (p == 31) begin
                    dup = 0;
                    for (int i = 0; i < nfinished && i < 256; i++)
                        if (ids[i] == cur_id) dup = 1;
                    if (rsv_bad || (cur_flags & ~flag_mask) != 0) chunk_fault(ST_CHDR_BAD);
                    else if (dup) chunk_fault(ST_DUP);
                    else if (asm_word > {24'd0, max_bytes}) chunk_fault(ST_PAY_SHORT);
                    else begin
                        if (nfinished < 256) ids[nfinished] = cur_id;
                        pay_left = asm_word;
                        hash_run = 64'd14695981039346656037;
                        if (pay_left == 0) r.done = close_payload();
                        else phase = PH_PAYLOAD;
                    end
                end
                fpos = fpos + 1;
            end
            PH_PAYLOAD: begin
                r.pv = 1;
                r.pb = b;
                hash_run = (hash_run ^ 64'(b)) * PRIME;
                pay_left--;
                if (pay_left == 0) r.done = close_payload();
            end
            PH_TRAIL: chunk_fault(ST_TRAIL);
            default: ;
        endcase
        r.id = cur_id;
        r.ver = cur_ver;
        r.flags = cur_flags;
        r.len = (phase == PH_FILE) ? 40'd0 : asm_word[39:0];
        r.fin = lst;
        r.status = lst ? verdict() : ST_BUSY;
        result_q.insert(result_q.size(), r);
        if (lst) restart();
    endtask

    task automatic cmp(input string name, input logic [63:0] e, input logic [63:0] a);
        if (e !== a) begin
            $error("%s: expected %0h, got %0h", name, e, a);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        byte_result_t e;
        if (!aresetn) begin
            exp_version <= RST_EXPECTED_VERSION;
            max_bytes <= RST_MAX_FILE_BYTES;
            max_chunk_cnt <= RST_MAX_CHUNKS;
            flag_mask <= RST_KNOWN_FLAG_MASK;
            restart();
            result_q.delete();
            fail_count = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_EXPECTED_VERSION: exp_version <= cfg_wr_data[31:0];
                    REG_MAX_FILE_BYTES:   max_bytes <= cfg_wr_data;
                    REG_MAX_CHUNKS:       max_chunk_cnt <= cfg_wr_data[8:0];
                    REG_KNOWN_FLAG_MASK:  flag_mask <= cfg_wr_data[31:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) predict_byte(s_data_byte, s_last);
            if (m_valid && m_ready) begin
                if (result_q.size() == 0) begin
                    $error("unexpected transfer on result channel");
                    fail_count++;
                end else begin
                    e = result_q.pop_front();
                    cmp("payload_valid", e.pv, m_payload_valid);
                    cmp("payload_byte", e.pb, m_payload_byte);
                    cmp("chunk_done", e.done, m_chunk_done);
                    cmp("chunk_id", e.id, m_chunk_id);
                    cmp("chunk_version", e.ver, m_chunk_version);
                    cmp("chunk_flags", e.flags, m_chunk_flags);
                    cmp("chunk_length", e.len, m_chunk_length);
                    cmp("finished", e.fin, m_finished);
                    cmp("status", e.status, m_status);
                end
            end
        end
        pending = result_q.size();
    end
endmodule

// ----- tb/chunk_container_checker_top_tb.sv -----
module chunk_container_checker_top_tb;
    import ccc_pkg::*;

    logic        aclk, aresetn;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [39:0] cfg_wr_data;
    logic        s_valid, s_ready, s_last;
    logic [7:0]  s_data_byte;
    logic        m_valid, m_ready;
    logic        m_payload_valid, m_chunk_done, m_finished;
    logic [7:0]  m_payload_byte;
    logic [31:0] m_chunk_id, m_chunk_version, m_chunk_flags;
    logic [39:0] m_chunk_length;
    logic [3:0]  m_status;
    int          fail_count, pending;
    int          sent;
    logic        quiet, hold_off;
    logic [31:0] cfg_version, cfg_mask;
    logic [39:0] cfg_max_bytes;
    logic [8:0]  cfg_max_chunks;
    byte unsigned file_q[$];

    chunk_container_checker_top uut (.*);
    chunk_container_checker_mon mon (.*);

    initial begin
        aclk = 0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #40000000;
        $display("** chunk_container_checker_top: FAILED **");
        $finish;
    end

    // receiver: random stalls, one long hold-off
    initial begin
        m_ready = 0;
        forever begin
            @(posedge aclk);
            if (hold_off) begin
                m_ready <= 0;
                repeat (300) @(posedge aclk);
                hold_off = 0;
            end
            m_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 16);
        end
    end

    task automatic cfg_write(input logic [1:0] idx, input logic [39:0] v);
        cfg_wr_en <= 1; cfg_index <= idx; cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 0;
    endtask

    task automatic set_regs(input logic [31:0] ver, input logic [39:0] mb,
                            input logic [8:0] mc, input logic [31:0] fm);
        while (pending != 0) @(posedge aclk);
        repeat (600) @(posedge aclk);
        cfg_version = ver; cfg_max_bytes = mb; cfg_max_chunks = mc; cfg_mask = fm;
        cfg_write(REG_EXPECTED_VERSION, {8'd0, ver});
        cfg_write(REG_MAX_FILE_BYTES, mb);
        cfg_write(REG_MAX_CHUNKS, {31'd0, mc});
        cfg_write(REG_KNOWN_FLAG_MASK, {8'd0, fm});
    endtask

    task automatic put_word(input logic [63:0] v, input int n);
        for (int i = 0; i < n; i++) file_q.insert(file_q.size(), v[8*i +: 8]);
    endtask

    task automatic send_file();
        for (int i = 0; i < file_q.size(); i++) begin
            if (!quiet)
                while ($urandom_range(99) < 16) begin
                    s_valid <= 0;
                    @(posedge aclk);
                end
            s_valid <= 1;
            s_data_byte <= file_q[i];
            s_last <= (i == file_q.size() - 1);
            @(posedge aclk iff s_ready);
            sent++;
        end
        s_valid <= 0;
        file_q.delete();
    endtask

    // builds a file of n chunks; mode 0 well formed, mode 1 random chunk defects, else one defect
    task automatic build_file(input int n, input int maxpay, input int mode);
        logic [31:0] ids[$];
        logic [63:0] h, total;
        int plen, at;
        byte unsigned pay[$];
        file_q.delete();
        put_word("ETATSX2P", 8);
        put_word(cfg_version, 4);
        put_word(32, 4);
        put_word(n, 4);
        put_word(0, 4);
        put_word(0, 8);
        for (int c = 0; c < n; c++) begin
            logic [31:0] id;
            id = (mode != 0 && $urandom_range(9) == 0 && ids.size() > 0)
                 ? ids[$urandom_range(ids.size() - 1)] : $urandom;
            ids.insert(ids.size(), id);
            plen = $urandom_range(maxpay);
            pay.delete();
            h = 64'd14695981039346656037;
            for (int k = 0; k < plen; k++) begin
                pay.insert(pay.size(), $urandom);
                h = (h ^ 64'(pay[k])) * 64'd1099511628211;
            end
            if (mode != 0 && $urandom_range(19) == 0) h ^= 64'd1;
            put_word(id, 4);
            put_word($urandom, 4);
            put_word((mode != 0 && $urandom_range(19) == 0) ? $urandom : ($urandom & cfg_mask), 4);
            put_word((mode != 0 && $urandom_range(19) == 0) ? 32'd1 << $urandom_range(31) : 0, 4);
            put_word(plen, 8);
            put_word(h, 8);
            foreach (pay[k]) file_q.insert(file_q.size(), pay[k]);
        end
        if (mode == 2) repeat ($urandom_range(1, 3)) file_q.insert(file_q.size(), $urandom);
        if (mode == 3) repeat ($urandom_range(1, 20)) void'(file_q.pop_back());
        total = file_q.size();
        if (mode == 4) total ^= 64'd1 << $urandom_range(63);
        if (file_q.size() >= 32)
            for (int i = 0; i < 8; i++) file_q[24 + i] = total[8*i +: 8];
        if (mode == 5 && file_q.size() > 0) begin
            at = $urandom_range(file_q.size() - 1);
            file_q[at] = file_q[at] ^ (8'd1 << $urandom_range(7));
        end
    endtask

    initial begin
        aresetn = 0; cfg_wr_en = 0; cfg_index = 0; cfg_wr_data = 0;
        s_valid = 0; s_data_byte = 0; s_last = 0;
        quiet = 0; hold_off = 0; sent = 0;
        cfg_version = 1; cfg_max_bytes = 40'd268435456; cfg_max_chunks = 256; cfg_mask = 1;
        repeat (4) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed
        build_file(0, 0, 0); send_file();
        build_file(2, 3, 0); send_file();
        file_q.delete(); repeat (5) file_q.insert(file_q.size(), 8'hFF); send_file();
        build_file(1, 0, 0); file_q[0] = 8'h00; send_file();
        build_file(1, 2, 0); file_q[8] = 8'h07; send_file();
        build_file(1, 2, 0); file_q[12] = 8'h21; send_file();
        build_file(1, 2, 0); file_q[20] = 8'h80; send_file();
        build_file(1, 2, 0); file_q.insert(file_q.size(), 8'h00); send_file();
        build_file(1, 2, 0); file_q[16 + 32 + 16] = 8'hFF; file_q[16 + 32 + 20] = 8'hFF;
        send_file();
        build_file(1, 2, 0); void'(file_q.pop_back()); send_file();

        set_regs(32'hFFFF_FFFF, 40'hFF_FFFF_FFFF, 9'd511, 32'hFFFF_FFFF);
        build_file(3, 4, 0); send_file();
        build_file(2, 2, 0); file_q[44] = 8'hA5; send_file();

        set_regs(32'd0, 40'd32, 9'd0, 32'd0);
        build_file(0, 0, 0); send_file();
        build_file(1, 0, 0); send_file();
        set_regs(32'h1234_5678, 40'd100, 9'd2, 32'h0000_00F0);
        build_file(2, 10, 0); send_file();
        build_file(3, 2, 0); send_file();

        // long receiver hold-off with the sender pushing
        hold_off = 1;
        build_file(3, 30, 0); send_file();

        quiet = 1;
        build_file(4, 20, 0); send_file();
        build_file(4, 20, 1); send_file();
        quiet = 0;

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: set_regs(32'd1, 40'd268435456, 9'd256, 32'd1);
                1: set_regs($urandom, 40'd300, 9'd5, $urandom);
                2: set_regs($urandom, 40'hFF_FFFF_FFFF, 9'd300, 32'hFFFF_FFFF);
                default: set_regs($urandom, 40'd4000, 9'd256, $urandom);
            endcase
            while (sent < 400 * (ph + 1) + 300) begin
                int m;
                m = ($urandom_range(9) < 6) ? 0 : $urandom_range(1, 5);
                build_file($urandom_range(0, 6), 12, m);
                send_file();
            end
        end
        // one file with many chunks to stretch the id search
        build_file(12, 2, 1); send_file();

        while (pending != 0) @(posedge aclk);
        repeat (600) @(posedge aclk);
        if (fail_count == 0)
            $display("** chunk_container_checker_top: PASSED **");
        else
            $display("** chunk_container_checker_top: FAILED **");
        $finish;
    end
endmodule
